### hw/rtl/ppsf_pkg.sv
// shared types, constants and register codes for the pulse period speed filter
package ppsf_pkg;

    localparam int TIME_W     = 32;
    localparam int DEB_W      = 16;
    localparam int MINP_W     = 20;
    localparam int STOP_W     = 32;
    localparam int SCALE_W    = 36;
    localparam int SPEED_W    = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 36;
    localparam int CNT_W      = 32;

    localparam int DIV_STEPS  = SCALE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int MUL_A_W    = SCALE_W + 6;
    localparam int MUL_B_W    = SPEED_W + 8;
    localparam int SUM_W      = MUL_A_W + 1;

    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_PER  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STOP_TO  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE    = 2'd3;

    localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 16'd500;
    localparam logic [MINP_W-1:0]  MIN_PER_RST  = 20'd0;
    localparam logic [STOP_W-1:0]  STOP_TO_RST  = 32'd2000000;
    localparam logic [SCALE_W-1:0] SCALE_RST    = 36'd0;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'd64000;
    localparam logic [SPEED_W-1:0] LOW_SPEED = 16'd1280;
    localparam logic [SCALE_W-1:0] SPIKE_RAW = 36'd40960;

    localparam logic [5:0] RISE_RAW_W = 6'd51;
    localparam logic [7:0] RISE_CUR_W = 8'd205;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic [DEB_W-1:0]   debounce_us;
        logic [MINP_W-1:0]  min_period_us;
        logic [STOP_W-1:0]  stop_timeout_us;
        logic [SCALE_W-1:0] speed_scale;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [SCALE_W-1:0] dividend;
        logic [TIME_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [SCALE_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic               valid;
        logic [SPEED_W-1:0] speed;
        logic               taken;
    } res_t;

endpackage

### hw/rtl/pulse_period_speed_filter.sv
// Wheel pulse speedometer: sensor edge and update tick beats, each with a microsecond
// timestamp, produce one result beat carrying the filtered speed (Q8 kph) and a flag
// telling whether an edge was taken as a pulse. One beat is processed at a time and
// s_tready is low while it is in work. Edge beats and ticks that need no new speed
// go from accept through S_EVAL and S_DEC to S_OUT; a tick with a fresh period runs
// a 36-step serial divider for speed_scale / period, then S_MUL and, if rising, S_SUM.
// The result register lets a new beat be accepted while the previous result waits.
// Configuration writes are to be made only while idle; the block does not enforce it.
module pulse_period_speed_filter
    import ppsf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // time_us[31:0]
    input  logic                  s_tuser,   // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // speed_q8[15:0]
    output logic                  m_tuser    // pulse_taken
);

    cfg_t         cfg_reg;
    res_t         res;
    div_req_t     div_req;
    div_rsp_t     div_rsp;
    logic         out_free;
    logic         m_tvalid_reg;
    logic [15:0]  m_tdata_reg;
    logic         m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_us     <= DEBOUNCE_RST;
            cfg_reg.min_period_us   <= MIN_PER_RST;
            cfg_reg.stop_timeout_us <= STOP_TO_RST;
            cfg_reg.speed_scale     <= SCALE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DEBOUNCE: cfg_reg.debounce_us     <= cfg_wdata[DEB_W-1:0];
                REG_MIN_PER:  cfg_reg.min_period_us   <= cfg_wdata[MINP_W-1:0];
                REG_STOP_TO:  cfg_reg.stop_timeout_us <= cfg_wdata[STOP_W-1:0];
                REG_SCALE:    cfg_reg.speed_scale     <= cfg_wdata[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res.valid) begin
            m_tdata_reg <= res.speed;
            m_tuser_reg <= res.taken;
        end
    end

    ppsf_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .in_time  (s_tdata[TIME_W-1:0]),
        .out_free (out_free),
        .res      (res),
        .div_req  (div_req),
        .div_rsp  (div_rsp)
    );

    ppsf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### hw/rtl/ppsf_div.sv
// serial restoring divider, one quotient bit per cycle
module ppsf_div
    import ppsf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [SCALE_W-1:0]   quo_reg, quo_next;
    logic [TIME_W-1:0]    dvs_reg, dvs_next;
    logic [TIME_W:0]      shifted;
    logic [TIME_W:0]      trial;

    assign shifted = {rem_reg, quo_reg[SCALE_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = trial[TIME_W-1:0];
                quo_next = {quo_reg[SCALE_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[TIME_W-1:0];
                quo_next = {quo_reg[SCALE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### hw/rtl/ppsf_core.sv
// sequencer with pulse state, timing checks and speed filter
module ppsf_core
    import ppsf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_kind,
    input  logic [TIME_W-1:0] in_time,
    input  logic              out_free,
    output res_t              res,
    output div_req_t          div_req,
    input  div_rsp_t          div_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic               kind_reg, kind_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic [TIME_W-1:0]  gap_e_reg, gap_e_next;
    logic [TIME_W-1:0]  gap_p_reg, gap_p_next;
    logic [TIME_W-1:0]  edge_time_reg, edge_time_next;
    logic               edge_seen_reg, edge_seen_next;
    logic [TIME_W-1:0]  pulse_time_reg, pulse_time_next;
    logic               pulse_seen_reg, pulse_seen_next;
    logic [TIME_W-1:0]  period_reg, period_next;
    logic [CNT_W-1:0]   pulse_total_reg, pulse_total_next;
    logic [CNT_W-1:0]   processed_reg, processed_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic               taken_reg, taken_next;
    logic [MUL_A_W-1:0] mul_a_reg, mul_a_next;
    logic [MUL_B_W-1:0] mul_b_reg, mul_b_next;

    logic               chatter;
    logic               timed_out;
    logic [SCALE_W-1:0] raw;
    logic               spike;
    logic [SCALE_W:0]   fall_sum;
    logic [SUM_W-1:0]   rise_sum;
    logic [SUM_W-9:0]   rise_val;

    assign chatter   = (gap_e_reg < TIME_W'(cfg.debounce_us)) ||
                       (gap_e_reg < TIME_W'(cfg.min_period_us));
    assign timed_out = !pulse_seen_reg || (gap_p_reg > cfg.stop_timeout_us);
    assign raw       = div_rsp.quotient;
    assign spike     = (speed_reg < LOW_SPEED) && (raw > SPIKE_RAW);
    assign fall_sum  = {1'b0, raw} + (SCALE_W + 1)'(speed_reg);
    assign rise_sum  = SUM_W'(mul_a_reg) + SUM_W'(mul_b_reg);
    assign rise_val  = rise_sum[SUM_W-1:8];

    always_comb begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        time_next        = time_reg;
        gap_e_next       = gap_e_reg;
        gap_p_next       = gap_p_reg;
        edge_time_next   = edge_time_reg;
        edge_seen_next   = edge_seen_reg;
        pulse_time_next  = pulse_time_reg;
        pulse_seen_next  = pulse_seen_reg;
        period_next      = period_reg;
        pulse_total_next = pulse_total_reg;
        processed_next   = processed_reg;
        speed_next       = speed_reg;
        taken_next       = taken_reg;
        mul_a_next       = mul_a_reg;
        mul_b_next       = mul_b_reg;
        div_req.start    = 1'b0;
        div_req.dividend = cfg.speed_scale;
        div_req.divisor  = period_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    kind_next  = in_kind;
                    time_next  = in_time;
                    taken_next = 1'b0;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                gap_e_next = time_reg - edge_time_reg;
                gap_p_next = time_reg - pulse_time_reg;
                state_next = S_DEC;
            end
            S_DEC: begin
                state_next = S_OUT;
                if (kind_reg == KIND_EDGE) begin
                    edge_time_next = time_reg;
                    if (!edge_seen_reg) begin
                        edge_seen_next   = 1'b1;
                        pulse_seen_next  = 1'b1;
                        pulse_time_next  = time_reg;
                        period_next      = '0;
                        pulse_total_next = pulse_total_reg + 1'b1;
                        taken_next       = 1'b1;
                    end else if (!chatter) begin
                        period_next      = timed_out ? '0 : gap_p_reg;
                        pulse_seen_next  = 1'b1;
                        pulse_time_next  = time_reg;
                        pulse_total_next = pulse_total_reg + 1'b1;
                        taken_next       = 1'b1;
                    end
                end else begin
                    if (timed_out) begin
                        speed_next = '0;
                    end else if (pulse_total_reg != processed_reg) begin
                        processed_next = pulse_total_reg;
                        if (period_reg != '0) begin
                            div_req.start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                state_next = S_OUT;
                if (!spike) begin
                    if (speed_reg == '0) begin
                        speed_next = (raw > SCALE_W'(SPEED_MAX)) ? SPEED_MAX
                                                                 : raw[SPEED_W-1:0];
                    end else if (raw < SCALE_W'(speed_reg)) begin
                        speed_next = fall_sum[SPEED_W:1];
                    end else begin
                        mul_a_next = MUL_A_W'(raw) * MUL_A_W'(RISE_RAW_W);
                        mul_b_next = MUL_B_W'(speed_reg) * MUL_B_W'(RISE_CUR_W);
                        state_next = S_SUM;
                    end
                end
            end
            S_SUM: begin
                speed_next = (rise_val > (SUM_W - 8)'(SPEED_MAX)) ? SPEED_MAX
                                                                 : rise_val[SPEED_W-1:0];
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            edge_time_reg   <= '0;
            edge_seen_reg   <= 1'b0;
            pulse_time_reg  <= '0;
            pulse_seen_reg  <= 1'b0;
            period_reg      <= '0;
            pulse_total_reg <= '0;
            processed_reg   <= '0;
            speed_reg       <= '0;
            taken_reg       <= 1'b0;
        end else begin
            state_reg       <= state_next;
            edge_time_reg   <= edge_time_next;
            edge_seen_reg   <= edge_seen_next;
            pulse_time_reg  <= pulse_time_next;
            pulse_seen_reg  <= pulse_seen_next;
            period_reg      <= period_next;
            pulse_total_reg <= pulse_total_next;
            processed_reg   <= processed_next;
            speed_reg       <= speed_next;
            taken_reg       <= taken_next;
        end
        kind_reg  <= kind_next;
        time_reg  <= time_next;
        gap_e_reg <= gap_e_next;
        gap_p_reg <= gap_p_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res.valid = (state_reg == S_OUT) && out_free;
    assign res.speed = speed_reg;
    assign res.taken = taken_reg;

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide wait");

    a_div_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && !div_rsp.done) |=> (state_reg == S_DIV))
        else $error("left divide wait before quotient was ready");

    a_speed_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> (speed_reg <= SPEED_MAX))
        else $error("speed above clamp limit");

    a_tick_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && kind_reg == KIND_TICK) |-> !taken_reg)
        else $error("tick beat flagged as taken pulse");

    a_out_return: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after result");
`endif

endmodule
